// ===== hdl/pilc_pkg.sv =====
package pilc_pkg;

    localparam int COEF_W     = 24;
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_W     = 16;
    localparam int Y_W        = 36;
    localparam int WRAP_STEPS = 16;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [DATA_W-1:0] PI_Q16      = 32'sd205887;
    localparam logic signed [DATA_W-1:0] DATA_MAX    = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] DATA_MIN    = 32'sh8000_0000;
    localparam logic [Y_W-1:0]           TWO_PI_Y    = 36'd411774;
    // bias of pi plus 2^15 periods keeps the reduced value non-negative
    localparam logic [Y_W-1:0]           WRAP_BIAS   =
        (TWO_PI_Y << (WRAP_STEPS - 1)) + 36'd205887;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF  = 59'sd32768;
    localparam logic signed [COEF_W-1:0] GAIN_RESET  = 24'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN = 4'd0,
        REG_LEAD_CUR  = 4'd1,
        REG_LEAD_PREV = 4'd2,
        REG_LEAD_FB   = 4'd3,
        REG_INT_COEF  = 4'd4,
        REG_LEAD_EN   = 4'd5,
        REG_INT_EN    = 4'd6,
        REG_WRAP      = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] prop_gain;
        logic signed [COEF_W-1:0] lead_cur;
        logic signed [COEF_W-1:0] lead_prev;
        logic signed [COEF_W-1:0] lead_fb;
        logic signed [COEF_W-1:0] int_coef;
        logic                     lead_en;
        logic                     int_en;
        logic                     wrap_en;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_ERR = 3'd0,
        MUL_K1  = 3'd1,
        MUL_K2  = 3'd2,
        MUL_K3  = 3'd3,
        MUL_INT = 3'd4
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic             load;
        logic             wrap_step;
        logic [CNT_W-1:0] wrap_shift;
        logic             wrap_fin;
        logic             mul_en;
        mul_sel_t         mul_sel;
        acc_op_t          acc_op;
        logic             err_load;
        logic             lead_from_prod;
        logic             lead_from_acc;
        logic             inc_load;
        logic             integ_add;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic frozen;
        logic out_free;
    } dp_sts_t;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DIFF_W-1:0] v);
        if (v[DIFF_W-1] != v[DIFF_W-2]) begin
            return v[DIFF_W-1] ? DATA_MIN : DATA_MAX;
        end
        return v[DATA_W-1:0];
    endfunction

    // round half up to Q16.16, then saturate
    function automatic logic signed [DATA_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]        t;
        logic signed [ACC_W-FRAC_W-1:0] q;
        t = v + ROUND_HALF;
        q = t[ACC_W-1:FRAC_W];
        if ((&q[ACC_W-FRAC_W-1:DATA_W-1]) || !(|q[ACC_W-FRAC_W-1:DATA_W-1])) begin
            return q[DATA_W-1:0];
        end
        return q[ACC_W-FRAC_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

endpackage

// ===== hdl/pi_lead_controller_step_core.sv =====
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_reference, s_measurement, s_actuator_saturated
// m_        out        m_valid / m_ready      m_drive
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The time from acceptance to the result register grows with the mode: the lead filter, the
// integrator and angle wrap each add steps to the base path. It is set by the single shared
// 24 x 33 multiplier and by the reduction of the error modulo two pi, which tests one shifted
// multiple of two pi per step.
// Reset (aresetn low, synchronous) restores the register defaults and clears the held error,
// lead and integral. A result waiting on m_ready holds the core in its delivery step; a new
// sample is still taken while the previous result waits in the output register.
module pi_lead_controller_step_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pilc_pkg::DATA_W-1:0] s_reference,
    input  logic signed [pilc_pkg::DATA_W-1:0] s_measurement,
    input  logic                               s_actuator_saturated,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pilc_pkg::DATA_W-1:0] m_drive,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pilc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pilc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pilc_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // hold the coefficient and mode registers; drop writes beyond the list
    pilc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequence one transaction: wrap, scale, lead, integrate, deliver
    pilc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .cfg      (cfg),
        .sts      (sts),
        .cmd      (cmd)
    );

    // shared multiplier, accumulator, held state and output register
    pilc_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_reference          (s_reference),
        .s_measurement        (s_measurement),
        .s_actuator_saturated (s_actuator_saturated),
        .cfg                  (cfg),
        .cmd                  (cmd),
        .sts                  (sts),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive              (m_drive)
    );

endmodule

// ===== hdl/pilc_cfg_regs.sv =====
module pilc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pilc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pilc_pkg::CFG_DATA_W-1:0] cfg_data,
    output pilc_pkg::cfg_t                  cfg
);
    import pilc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PROP_GAIN: cfg_next.prop_gain = $signed(cfg_data[COEF_W-1:0]);
                REG_LEAD_CUR:  cfg_next.lead_cur  = $signed(cfg_data[COEF_W-1:0]);
                REG_LEAD_PREV: cfg_next.lead_prev = $signed(cfg_data[COEF_W-1:0]);
                REG_LEAD_FB:   cfg_next.lead_fb   = $signed(cfg_data[COEF_W-1:0]);
                REG_INT_COEF:  cfg_next.int_coef  = $signed(cfg_data[COEF_W-1:0]);
                REG_LEAD_EN:   cfg_next.lead_en   = cfg_data[0];
                REG_INT_EN:    cfg_next.int_en    = cfg_data[0];
                REG_WRAP:      cfg_next.wrap_en   = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain <= GAIN_RESET;
            cfg_reg.lead_cur  <= '0;
            cfg_reg.lead_prev <= '0;
            cfg_reg.lead_fb   <= '0;
            cfg_reg.int_coef  <= '0;
            cfg_reg.lead_en   <= 1'b0;
            cfg_reg.int_en    <= 1'b0;
            cfg_reg.wrap_en   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/pilc_ctrl.sv =====
module pilc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pilc_pkg::cfg_t    cfg,
    input  pilc_pkg::dp_sts_t sts,
    output pilc_pkg::dp_cmd_t cmd
);
    import pilc_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_WRAP    = 14'b00000000000010,
        ST_WFIN    = 14'b00000000000100,
        ST_MUL_E   = 14'b00000000001000,
        ST_RND_E   = 14'b00000000010000,
        ST_MUL_K1  = 14'b00000000100000,
        ST_MUL_K2  = 14'b00000001000000,
        ST_MUL_K3  = 14'b00000010000000,
        ST_ACC_SUB = 14'b00000100000000,
        ST_RND_L   = 14'b00001000000000,
        ST_MUL_I   = 14'b00010000000000,
        ST_RND_I   = 14'b00100000000000,
        ST_ADD_I   = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             int_go;

    assign in_ready = (state_reg == ST_IDLE);
    assign int_go   = cfg.int_en && !sts.frozen;

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        cmd                = '0;
        cmd.mul_sel        = MUL_ERR;
        cmd.acc_op         = ACC_HOLD;
        cmd.wrap_shift     = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(WRAP_STEPS - 1);
                    state_next = cfg.wrap_en ? ST_WRAP : ST_MUL_E;
                end
            end
            ST_WRAP: begin
                cmd.wrap_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_WFIN;
                end
            end
            ST_WFIN: begin
                cmd.wrap_fin = 1'b1;
                state_next   = ST_MUL_E;
            end
            ST_MUL_E: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR;
                state_next  = ST_RND_E;
            end
            ST_RND_E: begin
                cmd.err_load = 1'b1;
                if (cfg.lead_en) begin
                    state_next = ST_MUL_K1;
                end else begin
                    cmd.lead_from_prod = 1'b1;
                    state_next = int_go ? ST_MUL_I : ST_OUT;
                end
            end
            ST_MUL_K1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K1;
                state_next  = ST_MUL_K2;
            end
            ST_MUL_K2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K2;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_K3;
            end
            ST_MUL_K3: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K3;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_ACC_SUB;
            end
            ST_ACC_SUB: begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_RND_L;
            end
            ST_RND_L: begin
                cmd.lead_from_acc = 1'b1;
                state_next = int_go ? ST_MUL_I : ST_OUT;
            end
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INT;
                state_next  = ST_RND_I;
            end
            ST_RND_I: begin
                cmd.inc_load = 1'b1;
                state_next   = ST_ADD_I;
            end
            ST_ADD_I: begin
                cmd.integ_add = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("controller stayed idle after an accepted transaction");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_wrap_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRAP && cnt_reg == '0) |=> (state_reg == ST_WFIN))
        else $error("angle reduction overran its step count");

    a_out_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && sts.out_free) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after delivery");

endmodule

// ===== hdl/pilc_dp.sv =====
module pilc_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic signed [pilc_pkg::DATA_W-1:0] s_reference,
    input  logic signed [pilc_pkg::DATA_W-1:0] s_measurement,
    input  logic                              s_actuator_saturated,
    input  pilc_pkg::cfg_t                    cfg,
    input  pilc_pkg::dp_cmd_t                 cmd,
    output pilc_pkg::dp_sts_t                 sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pilc_pkg::DATA_W-1:0] m_drive
);
    import pilc_pkg::*;

    logic signed [DATA_W-1:0] e_reg,  e_next;
    logic [Y_W-1:0]           y_reg,  y_next;
    logic                     frozen_reg, frozen_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg,  acc_next;
    logic signed [DATA_W-1:0] err_reg,  err_next;
    logic signed [DATA_W-1:0] lead_reg, lead_next;
    logic signed [DATA_W-1:0] inc_reg,  inc_next;
    logic signed [DATA_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0] prev_err_reg, prev_err_next;
    logic signed [DATA_W-1:0] prev_lead_reg, prev_lead_next;
    logic signed [DATA_W-1:0] prev_int_reg, prev_int_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;
    logic                     m_valid_reg, m_valid_next;

    logic signed [DIFF_W-1:0] diff;
    logic [Y_W-1:0]           wrap_sub;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [DIFF_W-1:0] lead_sum;
    logic signed [ACC_W-1:0]  prod_ext;

    assign diff     = {s_reference[DATA_W-1], s_reference}
                    - {s_measurement[DATA_W-1], s_measurement};
    assign wrap_sub = TWO_PI_Y << cmd.wrap_shift;
    assign lead_sum = {lead_reg[DATA_W-1], lead_reg} + {prev_lead_reg[DATA_W-1], prev_lead_reg};
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_ERR: begin
                mul_a = cfg.prop_gain;
                mul_b = {e_reg[DATA_W-1], e_reg};
            end
            MUL_K1: begin
                mul_a = cfg.lead_cur;
                mul_b = {err_reg[DATA_W-1], err_reg};
            end
            MUL_K2: begin
                mul_a = cfg.lead_prev;
                mul_b = {prev_err_reg[DATA_W-1], prev_err_reg};
            end
            MUL_K3: begin
                mul_a = cfg.lead_fb;
                mul_b = {prev_lead_reg[DATA_W-1], prev_lead_reg};
            end
            MUL_INT: begin
                mul_a = cfg.int_coef;
                mul_b = lead_sum;
            end
            default: begin
                mul_a = cfg.prop_gain;
                mul_b = {e_reg[DATA_W-1], e_reg};
            end
        endcase
    end

    always_comb begin
        e_next         = e_reg;
        y_next         = y_reg;
        frozen_next    = frozen_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        lead_next      = lead_reg;
        inc_next       = inc_reg;
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        prev_lead_next = prev_lead_reg;
        prev_int_next  = prev_int_reg;
        drive_next     = drive_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.load) begin
            e_next      = sat33(diff);
            y_next      = {{(Y_W-DIFF_W){diff[DIFF_W-1]}}, diff} + WRAP_BIAS;
            frozen_next = s_actuator_saturated;
            integ_next  = prev_int_reg;
        end
        if (cmd.wrap_step && (y_reg >= wrap_sub)) begin
            y_next = y_reg - wrap_sub;
        end
        if (cmd.wrap_fin) begin
            e_next = $signed(y_reg[DATA_W-1:0]) - PI_Q16;
        end
        if (cmd.mul_en) begin
            prod_next = mul_a * mul_b;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
        if (cmd.err_load) begin
            err_next = round_q16(prod_ext);
        end
        if (cmd.lead_from_prod) begin
            lead_next = round_q16(prod_ext);
        end
        if (cmd.lead_from_acc) begin
            lead_next = round_q16(acc_reg);
        end
        if (cmd.inc_load) begin
            inc_next = round_q16(prod_ext);
        end
        if (cmd.integ_add) begin
            integ_next = sat33({inc_reg[DATA_W-1], inc_reg}
                             + {prev_int_reg[DATA_W-1], prev_int_reg});
        end
        if (cmd.out_load) begin
            drive_next     = sat33({integ_reg[DATA_W-1], integ_reg}
                                 + {lead_reg[DATA_W-1], lead_reg});
            prev_err_next  = err_reg;
            prev_lead_next = lead_reg;
            prev_int_next  = integ_reg;
            m_valid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg      <= e_next;
        y_reg      <= y_next;
        frozen_reg <= frozen_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        err_reg    <= err_next;
        lead_reg   <= lead_next;
        inc_reg    <= inc_next;
        integ_reg  <= integ_next;
        drive_reg  <= drive_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            prev_lead_reg <= '0;
            prev_int_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            prev_err_reg  <= prev_err_next;
            prev_lead_reg <= prev_lead_next;
            prev_int_reg  <= prev_int_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign sts.frozen   = frozen_reg;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_drive      = drive_reg;

endmodule

// ===== test/pi_lead_controller_step_core_test.sv =====
`timescale 1ns / 1ps

module pi_lead_controller_step_core_test;
    import pilc_pkg::*;

    localparam int IDLE_PCT      = 12;
    localparam int RANDOM_ITEMS  = 1030;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    // allowance for the slowest sample, plus the output register
    localparam int TAIL_CYCLES   = 64;
    localparam int PLAN_LEN      = 43;

    // no register lives at this index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 4'hF;

    typedef enum logic { ROW_REG, ROW_SAMPLE } row_kind_t;

    // one line of the directed plan: either a register write or a sample,
    // with the drive value typed in where it is obvious
    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [DATA_W-1:0]  setpoint;
        logic signed [DATA_W-1:0]  measured;
        logic                      frozen;
        logic                      known;
        logic signed [DATA_W-1:0]  drive;
    } row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [DATA_W-1:0]  s_reference = '0;
    logic signed [DATA_W-1:0]  s_measurement = '0;
    logic                      s_actuator_saturated = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_drive;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Controller copy: coefficients and the three held values
    cfg_t                      law;
    logic signed [DATA_W-1:0]  held_error;
    logic signed [DATA_W-1:0]  held_lead;
    logic signed [DATA_W-1:0]  held_integral;

    logic signed [DATA_W-1:0]  drive_expected [$];
    logic signed [DATA_W-1:0]  head_drive;
    int                        mismatches = 0;

    // Flow control shared between the stimulus and the result side
    logic                      calm = 1'b0;
    int                        hold_asks = 0;
    int                        hold_seen = 0;
    int                        hold_left = 0;

    logic signed [DATA_W-1:0]  corners [7] = '{DATA_MIN, DATA_MAX, 32'sd0, -32'sd1, 32'sd1,
                                              PI_Q16, -PI_Q16};

    // Directed plan: reset defaults first, then angle wrap, gain extremes,
    // the lead filter with the integrator, frozen samples and saturation
    row_t plan [PLAN_LEN] = '{
        // defaults: unit gain, no lead, no integrator, so drive is the clamped error
        '{ROW_SAMPLE, '0, '0, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, DATA_MIN, 1'b0, 1'b1, DATA_MAX},
        '{ROW_SAMPLE, '0, '0, DATA_MIN, DATA_MAX, 1'b1, 1'b1, DATA_MIN},
        '{ROW_SAMPLE, '0, '0, 32'sh0003_0000, 32'sh0001_0000, 1'b0, 1'b1, 32'sh0002_0000},
        '{ROW_SAMPLE, '0, '0, -32'sd1, 32'sd0, 1'b1, 1'b1, -32'sd1},
        '{ROW_SAMPLE, '0, '0, 32'sd0, DATA_MIN, 1'b0, 1'b1, DATA_MAX},
        // wrap: plus pi folds onto minus pi, just under pi stays put
        '{ROW_REG, REG_WRAP, 32'h0000_0001, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, PI_Q16, 32'sd0, 1'b0, 1'b1, -PI_Q16},
        '{ROW_SAMPLE, '0, '0, 32'sd0, PI_Q16, 1'b0, 1'b1, -PI_Q16},
        '{ROW_SAMPLE, '0, '0, PI_Q16 - 32'sd1, 32'sd0, 1'b0, 1'b1, PI_Q16 - 32'sd1},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, DATA_MIN, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MIN, DATA_MAX, 1'b1, 1'b0, '0},
        // wrap off with junk in the upper bits, then gain at both extremes
        '{ROW_REG, REG_WRAP, 32'hFFFF_FFFE, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_PROP_GAIN, 32'hAB7F_FFFF, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, 32'sd0, 1'b0, 1'b1, DATA_MAX},
        '{ROW_SAMPLE, '0, '0, DATA_MIN, 32'sd0, 1'b0, 1'b1, DATA_MIN},
        '{ROW_REG, REG_PROP_GAIN, 32'h0080_0000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, 32'sd0, 1'b0, 1'b1, DATA_MIN},
        '{ROW_SAMPLE, '0, '0, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd0},
        // lead filter and integrator with modest coefficients
        '{ROW_REG, REG_PROP_GAIN, 32'h0001_0000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_CUR, 32'h0001_8000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_PREV, 32'h00FF_4000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_FB, 32'h0000_8000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_INT_COEF, 32'h0000_0800, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_EN, 32'h0000_0001, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_INT_EN, 32'h0000_0001, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0002_0000, 32'sh0000_8000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0002_0000, 32'sh0000_8000, 1'b1, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh0004_0000, 32'sh0001_0000, 1'b0, 1'b0, '0},
        '{ROW_REG, IDX_SPARE, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'shFFFF_0000, 32'sh0001_0000, 1'b0, 1'b0, '0},
        // extreme coefficients: drive the integral and the lead into saturation
        '{ROW_REG, REG_INT_COEF, 32'h007F_FFFF, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_FB, 32'h0080_0000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, DATA_MIN, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, DATA_MIN, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MIN, DATA_MAX, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MIN, DATA_MAX, 1'b1, 1'b0, '0},
        '{ROW_REG, REG_LEAD_CUR, 32'h0080_0000, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_LEAD_PREV, 32'h007F_FFFF, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_REG, REG_WRAP, 32'h0000_0001, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, DATA_MAX, DATA_MIN, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 32'sh1234_5678, 32'sh8765_4321, 1'b1, 1'b0, '0}
    };

    pi_lead_controller_step_core dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_reference          (s_reference),
        .s_measurement        (s_measurement),
        .s_actuator_saturated (s_actuator_saturated),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive              (m_drive),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Give up well beyond the slowest legal run
    initial begin
        #(4_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Controller arithmetic, all carried in 64 bits so nothing wraps early
    // ---------------------------------------------------------------------

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > longint'(DATA_MAX)) begin
            return DATA_MAX;
        end
        if (v < longint'(DATA_MIN)) begin
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // Q32 product sum back to Q16.16: add a half, floor, clamp
    function automatic logic signed [DATA_W-1:0] to_q16(input longint acc);
        longint t;
        t = acc + 64'sd32768;
        return clamp32(t >>> FRAC_W);
    endfunction

    // Fold an exact difference into [-pi, pi)
    function automatic longint fold_angle(input longint d);
        longint half_turn;
        longint r;
        half_turn = longint'(PI_Q16);
        r = (d + half_turn) % (2 * half_turn);
        if (r < 0) begin
            r = r + 2 * half_turn;
        end
        return r - half_turn;
    endfunction

    // Advance the controller copy by one sample and return its drive
    function automatic logic signed [DATA_W-1:0] predict_drive(
        input logic signed [DATA_W-1:0] setpoint,
        input logic signed [DATA_W-1:0] measured,
        input logic                     frozen
    );
        longint                   diff;
        longint                   e;
        longint                   pair;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] lead;
        logic signed [DATA_W-1:0] integ;
        diff = longint'(setpoint) - longint'(measured);
        if (law.wrap_en) begin
            e = fold_angle(diff);
        end else begin
            e = longint'(clamp32(diff));
        end
        err = to_q16(longint'(law.prop_gain) * e);
        if (law.lead_en) begin
            lead = to_q16(longint'(law.lead_cur) * longint'(err)
                          + longint'(law.lead_prev) * longint'(held_error)
                          - longint'(law.lead_fb) * longint'(held_lead));
        end else begin
            lead = err;
        end
        // trapezoid on lead and its last value; hold while the actuator is pinned
        if (law.int_en && !frozen) begin
            pair  = longint'(lead) + longint'(held_lead);
            integ = clamp32(longint'(to_q16(pair * longint'(law.int_coef)))
                            + longint'(held_integral));
        end else begin
            integ = held_integral;
        end
        held_error    = err;
        held_lead     = lead;
        held_integral = integ;
        return clamp32(longint'(integ) + longint'(lead));
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one sample, hold it until taken, then record its drive
    task automatic send_sample(
        input logic signed [DATA_W-1:0] setpoint,
        input logic signed [DATA_W-1:0] measured,
        input logic                     frozen,
        input logic                     known,
        input logic signed [DATA_W-1:0] known_drive
    );
        logic signed [DATA_W-1:0] want;
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid              <= 1'b1;
        s_reference          <= setpoint;
        s_measurement        <= measured;
        s_actuator_saturated <= frozen;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        want = predict_drive(setpoint, measured, frozen);
        if (known) begin
            want = known_drive;
        end
        drive_expected.push_back(want);
    endtask

    // Register write; valid stays up so back-to-back writes need no gap
    task automatic write_register(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_PROP_GAIN: law.prop_gain = data[COEF_W-1:0];
            REG_LEAD_CUR:  law.lead_cur  = data[COEF_W-1:0];
            REG_LEAD_PREV: law.lead_prev = data[COEF_W-1:0];
            REG_LEAD_FB:   law.lead_fb   = data[COEF_W-1:0];
            REG_INT_COEF:  law.int_coef  = data[COEF_W-1:0];
            REG_LEAD_EN:   law.lead_en   = data[0];
            REG_INT_EN:    law.int_en    = data[0];
            REG_WRAP:      law.wrap_en   = data[0];
            default:       ;
        endcase
    endtask

    // Stop offering and let every outstanding drive come back
    task automatic drain();
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Coefficient word: extremes, zero, full range or a band around a centre;
    // the bits above the field carry junk that must be masked
    function automatic logic [CFG_DATA_W-1:0] pick_coef(input int centre, input int span);
        logic [CFG_DATA_W-1:0] word;
        int                    roll;
        word = $urandom();
        roll = $urandom_range(9);
        case (roll)
            0:       word[COEF_W-1:0] = 24'h7F_FFFF;
            1:       word[COEF_W-1:0] = 24'h80_0000;
            2:       word[COEF_W-1:0] = '0;
            3, 4:    ;
            default: word[COEF_W-1:0] = 24'(int'($urandom_range(2 * span)) + centre - span);
        endcase
        return word;
    endfunction

    // Mostly a measurement tracking the setpoint around a drifting base,
    // with corner values and raw noise mixed in
    task automatic draw_sample(
        input  logic signed [DATA_W-1:0] base,
        output logic signed [DATA_W-1:0] setpoint,
        output logic signed [DATA_W-1:0] measured,
        output logic                     frozen
    );
        int roll;
        roll   = $urandom_range(99);
        frozen = ($urandom_range(3) == 0);
        if (roll < 70) begin
            setpoint = base + 32'(int'($urandom_range(1 << 18)) - (1 << 17));
            measured = setpoint + 32'(int'($urandom_range(1 << 18)) - (1 << 17));
        end else if (roll < 85) begin
            setpoint = corners[$urandom_range($size(corners) - 1)];
            measured = corners[$urandom_range($size(corners) - 1)];
        end else begin
            setpoint = $urandom();
            measured = $urandom();
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: stall at random, or for a long counted stretch on request
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare every delivered drive with the oldest one outstanding
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (drive_expected.size() == 0) begin
                report_mismatch($sformatf("drive %0d delivered with none outstanding",
                                          m_drive));
            end else begin
                head_drive = drive_expected.pop_front();
                if (m_drive !== head_drive) begin
                    report_mismatch($sformatf("drive %0d, predicted %0d",
                                              m_drive, head_drive));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        row_kind_t                prev_kind;
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measured;
        logic                     frozen;
        int                       n;
        int                       len;

        // power-on register values and cleared history
        law.prop_gain = GAIN_RESET;
        law.lead_cur  = '0;
        law.lead_prev = '0;
        law.lead_fb   = '0;
        law.int_coef  = '0;
        law.lead_en   = 1'b0;
        law.int_en    = 1'b0;
        law.wrap_en   = 1'b0;
        held_error    = '0;
        held_lead     = '0;
        held_integral = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed plan; settle the block before each run of writes
        prev_kind = ROW_SAMPLE;
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_REG) begin
                if (prev_kind == ROW_SAMPLE) begin
                    drain();
                end
                write_register(plan[i].idx, plan[i].data);
            end else begin
                send_sample(plan[i].setpoint, plan[i].measured, plan[i].frozen,
                            plan[i].known, plan[i].drive);
            end
            prev_kind = plan[i].kind;
        end

        // Random phases: fresh coefficients, then a burst of samples
        n = 0;
        while (n < RANDOM_ITEMS) begin
            drain();
            write_register(REG_PROP_GAIN, pick_coef(65536, 32768));
            write_register(REG_LEAD_CUR, pick_coef(0, 65536));
            write_register(REG_LEAD_PREV, pick_coef(0, 65536));
            write_register(REG_LEAD_FB, pick_coef(0, 65536));
            write_register(REG_INT_COEF, pick_coef(0, 4096));
            write_register(REG_LEAD_EN, $urandom());
            write_register(REG_INT_EN, $urandom());
            write_register(REG_WRAP, $urandom());
            if ($urandom_range(3) == 0) begin
                write_register(IDX_SPARE - 4'($urandom_range(7)), $urandom());
            end
            base = 32'(int'($urandom_range(1 << 24)) - (1 << 23));
            len  = $urandom_range(20, 80);
            for (int k = 0; k < len && n < RANDOM_ITEMS; k++) begin
                // a stretch with no idling on either side
                calm <= (n >= 250 && n < 420);
                // starve the output so the core backs up into its input
                if (n == 600 || n == 900) begin
                    hold_asks <= hold_asks + 1;
                end
                draw_sample(base, setpoint, measured, frozen);
                send_sample(setpoint, measured, frozen, 1'b0, '0);
                n++;
            end
        end

        // Let the last drives out, then allow for any stragglers
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pilc_pkg.sv
hdl/pilc_cfg_regs.sv
hdl/pilc_ctrl.sv
hdl/pilc_dp.sv
hdl/pi_lead_controller_step_core.sv
test/pi_lead_controller_step_core_test.sv
